### rtl/adsr_envelope_generator_assert.svh
`ifndef ADSR_ENVELOPE_GENERATOR_ASSERT_SVH
`define ADSR_ENVELOPE_GENERATOR_ASSERT_SVH

// Both macros assume the enclosing module has i_clk and i_rst_n.

// Consequent must hold on the same edge as the antecedent.
`define ADSR_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold on the edge after the antecedent.
`define ADSR_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/adsr_pkg.sv
package adsr_pkg;

    localparam int FRAC_BITS = 15;
    localparam int LVL_W     = 16;
    localparam int SMP_W     = 16;
    localparam int TICK_W    = 32;
    localparam int SR_W      = 18;
    localparam int MS_W      = 14;
    localparam int SUS_W     = 16;
    localparam int OP_W      = 2;
    localparam int STAGE_W   = 3;
    // samples per ms fits 9 bits for any 18-bit rate; times 14-bit ms gives 23 bits
    localparam int SPMS_W    = 9;
    localparam int LEN_W     = SPMS_W + MS_W;
    localparam int PROD_W    = 2 * (LVL_W + 1);

    // rate / 1000 as multiply by ceil(2^28 / 1000), exact for all 18-bit rates
    localparam int RECIP_W     = 19;
    localparam int RECIP_SHIFT = 28;
    localparam logic [RECIP_W-1:0] SPMS_RECIP = 19'd268436;

    localparam int DIV_STEPS = FRAC_BITS;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

    localparam logic [LVL_W-1:0] LVL_ONE = LVL_W'(1 << FRAC_BITS);
    localparam logic [TICK_W-1:0] TICK_MAX = '1;

    localparam int APB_AW    = 5;
    localparam int APB_DW    = 32;
    localparam int REG_IDX_W = 3;

    localparam logic [SR_W-1:0]  SAMPLE_RATE_RST = 18'd44100;
    localparam logic [MS_W-1:0]  ATTACK_MS_RST   = 14'd10;
    localparam logic [MS_W-1:0]  DECAY_MS_RST    = 14'd100;
    localparam logic [SUS_W-1:0] SUSTAIN_RST     = 16'd16384;
    localparam logic [MS_W-1:0]  RELEASE_MS_RST  = 14'd200;

    typedef enum logic [STAGE_W-1:0] {
        STG_IDLE    = 3'd0,
        STG_ATTACK  = 3'd1,
        STG_DECAY   = 3'd2,
        STG_SUSTAIN = 3'd3,
        STG_RELEASE = 3'd4,
        STG_DONE    = 3'd5
    } t_stage;

    typedef enum logic [OP_W-1:0] {
        OP_TICK     = 2'd0,
        OP_NOTE_ON  = 2'd1,
        OP_NOTE_OFF = 2'd2
    } t_opcode;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_SAMPLE_RATE = 3'd0,
        REG_ATTACK_MS   = 3'd1,
        REG_DECAY_MS    = 3'd2,
        REG_SUSTAIN     = 3'd3,
        REG_RELEASE_MS  = 3'd4
    } t_reg_idx;

    typedef enum logic [2:0] {
        DP_NONE,
        DP_EVAL,
        DP_DIV,
        DP_MUL1,
        DP_MUL2,
        DP_LEVEL,
        DP_SMUL,
        DP_PUSH
    } t_dp_op;

    typedef enum logic [3:0] {
        FSM_IDLE,
        FSM_WAIT,
        FSM_EVAL,
        FSM_DIV,
        FSM_MUL1,
        FSM_MUL2,
        FSM_LEVEL,
        FSM_SMUL,
        FSM_PUSH
    } t_fsm;

    typedef struct packed {
        logic   load;
        t_dp_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic tick_active;
        logic out_full;
    } t_dp_status;

    typedef struct packed {
        logic [SUS_W-1:0] sustain;
        logic [LEN_W-1:0] len_a;
        logic [LEN_W-1:0] len_d;
        logic [LEN_W-1:0] len_r;
    } t_cfg;

endpackage

### rtl/adsr_if.sv
interface adsr_in_if import adsr_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [OP_W-1:0]         opcode;
    logic signed [SMP_W-1:0] osc_sample;

    modport source (output valid, output opcode, output osc_sample, input ready);
    modport sink   (input valid, input opcode, input osc_sample, output ready);
endinterface

interface adsr_out_if import adsr_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [SMP_W-1:0] out_sample;
    logic [STAGE_W-1:0]      env_stage;
    logic                    note_done;

    modport source (output valid, output out_sample, output env_stage, output note_done,
                    input ready);
    modport sink   (input valid, input out_sample, input env_stage, input note_done,
                    output ready);
endinterface

### rtl/adsr_regs.sv
module adsr_regs import adsr_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    logic [SR_W-1:0]  r_sample_rate;
    logic [MS_W-1:0]  r_attack_ms;
    logic [MS_W-1:0]  r_decay_ms;
    logic [SUS_W-1:0] r_sustain;
    logic [MS_W-1:0]  r_release_ms;

    logic [SPMS_W-1:0] r_spms;
    logic [LEN_W-1:0]  r_len_a;
    logic [LEN_W-1:0]  r_len_d;
    logic [LEN_W-1:0]  r_len_r;

    logic [REG_IDX_W-1:0]      reg_idx;
    logic                      wr_en;
    logic [SR_W+RECIP_W-1:0]   spms_prod;

    assign reg_idx = paddr[APB_AW-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_rate <= SAMPLE_RATE_RST;
            r_attack_ms   <= ATTACK_MS_RST;
            r_decay_ms    <= DECAY_MS_RST;
            r_sustain     <= SUSTAIN_RST;
            r_release_ms  <= RELEASE_MS_RST;
        end else if (wr_en) begin
            case (reg_idx)
                REG_SAMPLE_RATE: r_sample_rate <= pwdata[SR_W-1:0];
                REG_ATTACK_MS:   r_attack_ms   <= pwdata[MS_W-1:0];
                REG_DECAY_MS:    r_decay_ms    <= pwdata[MS_W-1:0];
                REG_SUSTAIN:     r_sustain     <= pwdata[SUS_W-1:0];
                REG_RELEASE_MS:  r_release_ms  <= pwdata[MS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_SAMPLE_RATE: prdata = APB_DW'(r_sample_rate);
            REG_ATTACK_MS:   prdata = APB_DW'(r_attack_ms);
            REG_DECAY_MS:    prdata = APB_DW'(r_decay_ms);
            REG_SUSTAIN:     prdata = APB_DW'(r_sustain);
            REG_RELEASE_MS:  prdata = APB_DW'(r_release_ms);
            default:         prdata = '0;
        endcase
    end

    // Stage lengths are registered; the sample rate passes r_spms before r_len_*.
    assign spms_prod = (SR_W+RECIP_W)'(r_sample_rate) * (SR_W+RECIP_W)'(SPMS_RECIP);

    always_ff @(posedge i_clk) begin
        r_spms  <= spms_prod[RECIP_SHIFT+SPMS_W-1:RECIP_SHIFT];
        r_len_a <= LEN_W'(r_spms) * LEN_W'(r_attack_ms);
        r_len_d <= LEN_W'(r_spms) * LEN_W'(r_decay_ms);
        r_len_r <= LEN_W'(r_spms) * LEN_W'(r_release_ms);
    end

    assign o_cfg.sustain = r_sustain;
    assign o_cfg.len_a   = r_len_a;
    assign o_cfg.len_d   = r_len_d;
    assign o_cfg.len_r   = r_len_r;

endmodule

### rtl/adsr_ctrl.sv
`include "adsr_envelope_generator_assert.svh"

module adsr_ctrl import adsr_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    t_fsm                 r_state, n_state;
    logic [DIV_CNT_W-1:0] r_div_cnt, n_div_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= FSM_IDLE;
            r_div_cnt <= '0;
        end else begin
            r_state   <= n_state;
            r_div_cnt <= n_div_cnt;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_div_cnt  = r_div_cnt;
        o_in_ready = 1'b0;
        o_cmd.load = 1'b0;
        o_cmd.op   = DP_NONE;
        case (r_state)
            FSM_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = FSM_WAIT;
                end
            end
            // lets fresh register writes reach the stage lengths
            FSM_WAIT: n_state = FSM_EVAL;
            FSM_EVAL: begin
                o_cmd.op  = DP_EVAL;
                n_div_cnt = '0;
                n_state   = i_status.tick_active ? FSM_DIV : FSM_PUSH;
            end
            FSM_DIV: begin
                o_cmd.op = DP_DIV;
                if (r_div_cnt == DIV_LAST) begin
                    n_state = FSM_MUL1;
                end else begin
                    n_div_cnt = r_div_cnt + 1'b1;
                end
            end
            FSM_MUL1: begin
                o_cmd.op = DP_MUL1;
                n_state  = FSM_MUL2;
            end
            FSM_MUL2: begin
                o_cmd.op = DP_MUL2;
                n_state  = FSM_LEVEL;
            end
            FSM_LEVEL: begin
                o_cmd.op = DP_LEVEL;
                n_state  = FSM_SMUL;
            end
            FSM_SMUL: begin
                o_cmd.op = DP_SMUL;
                n_state  = FSM_PUSH;
            end
            FSM_PUSH: begin
                if (!i_status.out_full) begin
                    o_cmd.op = DP_PUSH;
                    n_state  = FSM_IDLE;
                end
            end
            default: n_state = FSM_IDLE;
        endcase
    end

    `ADSR_ASSERT_NXT(a_accept_starts, i_in_valid && o_in_ready, r_state == FSM_WAIT,
        "accepted transaction did not start processing")
    `ADSR_ASSERT_IMP(a_push_has_room, o_cmd.op == DP_PUSH, !i_status.out_full,
        "result pushed into a full output register")
    `ADSR_ASSERT_NXT(a_div_length, (r_state == FSM_DIV) && (r_div_cnt == DIV_LAST),
        r_state == FSM_MUL1, "divider did not finish after its last step")

endmodule

### rtl/adsr_dp.sv
`include "adsr_envelope_generator_assert.svh"

module adsr_dp import adsr_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_dp_cmd                 i_cmd,
    output t_dp_status              o_status,
    input  t_cfg                    i_cfg,
    input  logic [OP_W-1:0]         i_opcode,
    input  logic signed [SMP_W-1:0] i_osc_sample,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic signed [SMP_W-1:0] o_out_sample,
    output logic [STAGE_W-1:0]      o_env_stage,
    output logic                    o_note_done
);

    // envelope state
    t_stage              r_stage, n_stage;
    logic [TICK_W-1:0]   r_tick, n_tick;
    logic [LVL_W-1:0]    r_held, n_held;
    logic [LVL_W-1:0]    r_rel, n_rel;

    // per-transaction working registers
    logic [OP_W-1:0]         r_op;
    logic signed [SMP_W-1:0] r_samp;
    logic                    r_jump, n_jump;
    logic                    r_frac_one, n_frac_one;
    logic [LEN_W-1:0]        r_den, n_den;
    logic [LEN_W-1:0]        r_rem, n_rem;
    logic [FRAC_BITS-1:0]    r_quo, n_quo;
    logic signed [PROD_W-1:0] r_prod, n_prod;
    logic [LVL_W-1:0]        r_lvl, n_lvl;

    // output register
    logic                    r_out_valid;
    logic signed [SMP_W-1:0] r_out_sample;
    t_stage                  r_out_stage;
    logic                    r_out_done;

    logic                    tick_active;
    logic [TICK_W-1:0]       len_a_ext, len_ad;
    logic [TICK_W-1:0]       num;
    logic [LEN_W-1:0]        den;
    logic [LEN_W:0]          rem_sh;
    logic                    rem_ge;
    logic [LVL_W-1:0]        sus_use;
    logic [LVL_W-1:0]        frac;
    logic [LVL_W:0]          att_sum;
    logic [LVL_W-1:0]        att_lvl;
    logic [LVL_W-1:0]        prod_hi;
    logic [LVL_W-1:0]        sq_opnd;
    logic signed [LVL_W:0]   mul_a, mul_b;

    assign tick_active = (r_op == OP_TICK) &&
                         ((r_stage == STG_ATTACK) || (r_stage == STG_DECAY) ||
                          (r_stage == STG_SUSTAIN) || (r_stage == STG_RELEASE));

    assign o_status.tick_active = tick_active;
    assign o_status.out_full    = r_out_valid && !i_out_ready;

    // stage-end compares and divider operands
    assign len_a_ext = TICK_W'(i_cfg.len_a);
    assign len_ad    = len_a_ext + TICK_W'(i_cfg.len_d);

    always_comb begin
        case (r_stage)
            STG_ATTACK: begin
                num = r_tick;
                den = i_cfg.len_a;
            end
            STG_DECAY: begin
                num = (r_tick > len_a_ext) ? (r_tick - len_a_ext) : '0;
                den = i_cfg.len_d;
            end
            default: begin
                num = r_tick;
                den = i_cfg.len_r;
            end
        endcase
    end

    // one restoring step: quotient bit of (num << FRAC_BITS) / den
    assign rem_sh = {r_rem, 1'b0};
    assign rem_ge = rem_sh >= {1'b0, r_den};

    assign sus_use  = (i_cfg.sustain > LVL_ONE) ? LVL_ONE : i_cfg.sustain;
    assign frac     = r_frac_one ? LVL_ONE : LVL_W'(r_quo);
    assign att_sum  = (LVL_W+1)'(frac) + (LVL_W+1)'(r_rel);
    assign att_lvl  = (att_sum > (LVL_W+1)'(LVL_ONE)) ? LVL_ONE : att_sum[LVL_W-1:0];
    assign prod_hi  = r_prod[FRAC_BITS+LVL_W-1:FRAC_BITS];
    // decay squares the progress, release squares what is left of it
    assign sq_opnd  = (r_stage == STG_DECAY) ? frac : (LVL_ONE - frac);

    always_comb begin
        case (i_cmd.op)
            DP_MUL1: begin
                mul_a = signed'({1'b0, sq_opnd});
                mul_b = signed'({1'b0, sq_opnd});
            end
            DP_MUL2: begin
                mul_a = (r_stage == STG_DECAY) ? signed'({1'b0, LVL_ONE - sus_use})
                                               : signed'({1'b0, r_held});
                mul_b = signed'({1'b0, prod_hi});
            end
            DP_SMUL: begin
                mul_a = (LVL_W+1)'(r_samp);
                mul_b = signed'({1'b0, r_lvl});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        n_stage    = r_stage;
        n_tick     = r_tick;
        n_held     = r_held;
        n_rel      = r_rel;
        n_jump     = r_jump;
        n_frac_one = r_frac_one;
        n_den      = r_den;
        n_rem      = r_rem;
        n_quo      = r_quo;
        n_prod     = r_prod;
        n_lvl      = r_lvl;
        case (i_cmd.op)
            DP_EVAL: begin
                n_jump     = (r_stage == STG_ATTACK) ? (r_tick > len_a_ext)
                                                     : (r_tick > len_ad);
                n_frac_one = (den == '0) || (num >= TICK_W'(den));
                n_den      = den;
                n_rem      = num[LEN_W-1:0];
                n_prod     = '0;
                if (!tick_active) begin
                    case (r_op)
                        OP_NOTE_ON: begin
                            n_tick  = '0;
                            n_stage = STG_ATTACK;
                        end
                        OP_NOTE_OFF: begin
                            n_tick  = '0;
                            n_stage = STG_RELEASE;
                        end
                        default: ;
                    endcase
                end
            end
            DP_DIV: begin
                n_rem = rem_ge ? LEN_W'(rem_sh - {1'b0, r_den}) : rem_sh[LEN_W-1:0];
                n_quo = {r_quo[FRAC_BITS-2:0], rem_ge};
            end
            DP_MUL1, DP_MUL2, DP_SMUL: begin
                n_prod = mul_a * mul_b;
            end
            DP_LEVEL: begin
                case (r_stage)
                    STG_ATTACK: begin
                        if (r_jump) begin
                            n_stage = STG_DECAY;
                            n_lvl   = LVL_ONE;
                        end else begin
                            n_lvl  = att_lvl;
                            n_held = att_lvl;
                        end
                    end
                    STG_DECAY: begin
                        if (r_jump) begin
                            if (sus_use != '0) begin
                                n_stage = STG_SUSTAIN;
                                n_lvl   = sus_use;
                            end else begin
                                n_stage = STG_DONE;
                                n_lvl   = '0;
                            end
                        end else begin
                            n_lvl  = LVL_ONE - prod_hi;
                            n_held = LVL_ONE - prod_hi;
                        end
                    end
                    STG_SUSTAIN: begin
                        n_lvl  = sus_use;
                        n_held = sus_use;
                    end
                    default: begin
                        n_lvl = prod_hi;
                        n_rel = prod_hi;
                        if (prod_hi == '0) begin
                            n_stage = STG_DONE;
                        end
                    end
                endcase
                if (r_tick != TICK_MAX) begin
                    n_tick = r_tick + 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage     <= STG_IDLE;
            r_tick      <= '0;
            r_held      <= '0;
            r_rel       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_stage <= n_stage;
            r_tick  <= n_tick;
            r_held  <= n_held;
            r_rel   <= n_rel;
            if (i_cmd.op == DP_PUSH) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= i_opcode;
            r_samp <= i_osc_sample;
        end
        r_jump     <= n_jump;
        r_frac_one <= n_frac_one;
        r_den      <= n_den;
        r_rem      <= n_rem;
        r_quo      <= n_quo;
        r_prod     <= n_prod;
        r_lvl      <= n_lvl;
        if (i_cmd.op == DP_PUSH) begin
            // arithmetic shift of the product gives the floor
            r_out_sample <= r_prod[FRAC_BITS+SMP_W-1:FRAC_BITS];
            r_out_stage  <= r_stage;
            r_out_done   <= (r_stage == STG_DONE);
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_sample = r_out_sample;
    assign o_env_stage  = r_out_stage;
    assign o_note_done  = r_out_done;

    `ADSR_ASSERT_IMP(a_level_range, 1'b1, (r_held <= LVL_ONE) && (r_rel <= LVL_ONE),
        "held or release level above full scale")
    `ADSR_ASSERT_NXT(a_tick_saturates, (r_tick == TICK_MAX) && (i_cmd.op != DP_EVAL),
        r_tick == TICK_MAX, "tick counter wrapped")
    `ADSR_ASSERT_NXT(a_out_hold, o_out_valid && !i_out_ready,
        o_out_valid && $stable(o_out_sample) && $stable(o_env_stage) && $stable(o_note_done),
        "waiting result changed before it was taken")

endmodule

### rtl/adsr_envelope_generator.sv
// ADSR envelope generator.
// Input channel i_in carries an opcode (sample tick, note on, note off) and a
// signed oscillator sample. Output channel o_out returns one transaction per
// input: the sample scaled by the envelope level (zero for note events and
// while idle or done), the stage after the step, and a done flag.
// Stage timing and sustain level come from the APB registers: sample rate,
// attack, decay and release in ms, sustain in Q1.15. Write them only while
// no transaction is in flight.
// A tick in an active stage passes the wait and evaluate states, the 15-step
// serial divider that forms the stage progress, the shared multiplier passes
// and the level update before o_out.valid; every other transaction goes from
// evaluate straight to the output push. One transaction is processed at a time;
// i_in.ready returns when its result is moved into the output register.
// A result waiting in the output register does not block the next input.
// If the receiver stalls, the block holds its next result until the output
// register is free and accepts no input meanwhile.
// Reset (synchronous, active low) returns the registers to their defaults,
// the envelope to idle with counter and levels at zero, and empties the
// output register.
module adsr_envelope_generator import adsr_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    adsr_in_if.sink           i_in,
    adsr_out_if.source        o_out,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    t_cfg       cfg;
    t_dp_cmd    cmd;
    t_dp_status status;

    adsr_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    adsr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    adsr_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_status     (status),
        .i_cfg        (cfg),
        .i_opcode     (i_in.opcode),
        .i_osc_sample (i_in.osc_sample),
        .o_out_valid  (o_out.valid),
        .i_out_ready  (o_out.ready),
        .o_out_sample (o_out.out_sample),
        .o_env_stage  (o_out.env_stage),
        .o_note_done  (o_out.note_done)
    );

endmodule

### sim/adsr_envelope_generator_checker.sv
module adsr_envelope_generator_checker import adsr_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    adsr_in_if                i_in,
    adsr_out_if               i_out,
    input  logic              i_psel,
    input  logic              i_penable,
    input  logic              i_pwrite,
    input  logic [APB_AW-1:0] i_paddr,
    input  logic [APB_DW-1:0] i_pwdata,
    input  logic              i_pready,
    output int                o_mismatches,
    output int                o_outstanding,
    output int                o_compared
);

    typedef longint unsigned t_u64;

    typedef struct packed {
        logic signed [SMP_W-1:0] sample;
        logic [STAGE_W-1:0]      stage;
        logic                    done;
    } t_env_result;

    localparam t_u64 UNITY = 64'd1 << FRAC_BITS;

    // register shadow
    logic [SR_W-1:0]  rate_reg;
    logic [MS_W-1:0]  attack_reg;
    logic [MS_W-1:0]  decay_reg;
    logic [SUS_W-1:0] sustain_reg;
    logic [MS_W-1:0]  release_reg;

    // envelope state
    t_stage           env_st;
    logic [TICK_W-1:0] tick_cnt;
    t_u64             held_lvl;
    t_u64             rel_lvl;

    t_env_result envelope_results_q[$];
    int mismatches;
    int compared;

    function automatic t_u64 seg_len(logic [MS_W-1:0] ms);
        t_u64 spms;
        spms = rate_reg;
        spms = spms / 1000;
        return spms * ms;
    endfunction

    // num/den in Q15, full scale when den is zero or num reaches den
    function automatic t_u64 ratio_q15(t_u64 num, t_u64 den);
        t_u64 p;
        if (den == 0 || num >= den)
            return UNITY;
        p = (num << FRAC_BITS) / den;
        return (p > UNITY) ? UNITY : p;
    endfunction

    function automatic t_env_result shape_sample(logic [OP_W-1:0] op,
                                                 logic signed [SMP_W-1:0] smp);
        t_env_result res;
        t_u64 n, a, d, r, s, lvl, p, p2, q, curve;
        longint prod;
        n = tick_cnt;
        a = seg_len(attack_reg);
        d = seg_len(decay_reg);
        r = seg_len(release_reg);
        s = sustain_reg;
        if (s > UNITY)
            s = UNITY;
        lvl = 0;
        res.sample = '0;
        case (op)
            OP_NOTE_ON: begin
                tick_cnt = '0;
                env_st = STG_ATTACK;
            end
            OP_NOTE_OFF: begin
                tick_cnt = '0;
                env_st = STG_RELEASE;
            end
            OP_TICK: begin
                if (env_st != STG_IDLE && env_st != STG_DONE) begin
                    case (env_st)
                        STG_ATTACK: begin
                            if (n > a) begin
                                env_st = STG_DECAY;
                                lvl = UNITY;
                            end else begin
                                lvl = ratio_q15(n, a) + rel_lvl;
                                if (lvl > UNITY)
                                    lvl = UNITY;
                                held_lvl = lvl;
                            end
                        end
                        STG_DECAY: begin
                            if (n > a + d) begin
                                if (s > 0) begin
                                    env_st = STG_SUSTAIN;
                                    lvl = s;
                                end else begin
                                    env_st = STG_DONE;
                                    lvl = 0;
                                end
                            end else begin
                                // counter may sit below the attack length after a rewrite
                                p = ratio_q15((n > a) ? n - a : 64'd0, d);
                                p2 = (p * p) >> FRAC_BITS;
                                lvl = UNITY - (((UNITY - s) * p2) >> FRAC_BITS);
                                held_lvl = lvl;
                            end
                        end
                        STG_SUSTAIN: begin
                            lvl = s;
                            held_lvl = s;
                        end
                        default: begin
                            curve = 0;
                            if (r != 0 && n < r) begin
                                q = UNITY - ratio_q15(n, r);
                                curve = (q * q) >> FRAC_BITS;
                            end
                            lvl = (held_lvl * curve) >> FRAC_BITS;
                            if (lvl == 0)
                                env_st = STG_DONE;
                            rel_lvl = lvl;
                        end
                    endcase
                    if (tick_cnt != TICK_MAX)
                        tick_cnt = tick_cnt + 1'b1;
                    // arithmetic shift floors toward minus infinity
                    prod = longint'(smp) * longint'(lvl);
                    res.sample = SMP_W'(prod >>> FRAC_BITS);
                end
            end
            default: ;
        endcase
        res.stage = env_st;
        res.done = (env_st == STG_DONE);
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_env_result want;
        if (!i_rst_n) begin
            rate_reg = SAMPLE_RATE_RST;
            attack_reg = ATTACK_MS_RST;
            decay_reg = DECAY_MS_RST;
            sustain_reg = SUSTAIN_RST;
            release_reg = RELEASE_MS_RST;
            env_st = STG_IDLE;
            tick_cnt = '0;
            held_lvl = 0;
            rel_lvl = 0;
            envelope_results_q.delete();
            mismatches = 0;
            compared = 0;
        end else begin
            if (i_out.valid && i_out.ready) begin
                if (envelope_results_q.size() == 0) begin
                    $error("result transaction with nothing outstanding: out_sample %0d stage %0d",
                           i_out.out_sample, i_out.env_stage);
                    mismatches++;
                end else begin
                    want = envelope_results_q.pop_front();
                    compared++;
                    if (i_out.out_sample !== want.sample) begin
                        $error("out_sample mismatch: expected %0d, actual %0d",
                               $signed(want.sample), i_out.out_sample);
                        mismatches++;
                    end
                    if (i_out.env_stage !== want.stage) begin
                        $error("env_stage mismatch: expected %0d, actual %0d",
                               want.stage, i_out.env_stage);
                        mismatches++;
                    end
                    if (i_out.note_done !== want.done) begin
                        $error("note_done mismatch: expected %0d, actual %0d",
                               want.done, i_out.note_done);
                        mismatches++;
                    end
                end
            end
            if (i_in.valid && i_in.ready)
                envelope_results_q.push_back(shape_sample(i_in.opcode, i_in.osc_sample));
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (t_reg_idx'(i_paddr[APB_AW-1:2]))
                    REG_SAMPLE_RATE: rate_reg = i_pwdata[SR_W-1:0];
                    REG_ATTACK_MS:   attack_reg = i_pwdata[MS_W-1:0];
                    REG_DECAY_MS:    decay_reg = i_pwdata[MS_W-1:0];
                    REG_SUSTAIN:     sustain_reg = i_pwdata[SUS_W-1:0];
                    REG_RELEASE_MS:  release_reg = i_pwdata[MS_W-1:0];
                    default: ;
                endcase
            end
        end
        o_mismatches <= mismatches;
        o_compared <= compared;
        o_outstanding <= envelope_results_q.size();
    end

endmodule

### sim/adsr_envelope_generator_test.sv
module adsr_envelope_generator_test;
    import adsr_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 1000;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic pready;

    int mismatch_total;
    int outstanding;
    int compared_total;
    int burst_left;
    int items_sent;
    int settings_used;
    bit stress_go;
    bit stress_done;

    adsr_in_if  in_ch ();
    adsr_out_if out_ch ();

    adsr_envelope_generator uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    adsr_envelope_generator_checker env_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in          (in_ch),
        .i_out         (out_ch),
        .i_psel        (psel),
        .i_penable     (penable),
        .i_pwrite      (pwrite),
        .i_paddr       (paddr),
        .i_pwdata      (pwdata),
        .i_pready      (pready),
        .o_mismatches  (mismatch_total),
        .o_outstanding (outstanding),
        .o_compared    (compared_total)
    );

    always #2 i_clk = ~i_clk;

    initial begin
        #8000000;
        $display("adsr_envelope_generator_test: errors");
        $finish;
    end

    // output side: mixed stall pattern plus one long hold-off once random traffic runs
    initial begin : out_stall
        int span;
        int mode;
        out_ch.ready = 1'b0;
        stress_done = 1'b0;
        @(negedge i_clk);
        while (!i_rst_n) @(negedge i_clk);
        forever begin
            if (stress_go && !stress_done) begin
                stress_done = 1'b1;
                out_ch.ready <= 1'b0;
                repeat (400) @(negedge i_clk);
            end else begin
                mode = $urandom_range(0, 9);
                span = $urandom_range(10, 60);
                case (mode)
                    0, 1, 2, 3: begin
                        out_ch.ready <= 1'b1;
                        repeat (span) @(negedge i_clk);
                    end
                    9: begin
                        out_ch.ready <= 1'b0;
                        repeat ($urandom_range(20, 120)) @(negedge i_clk);
                    end
                    default: begin
                        repeat (span) begin
                            out_ch.ready <= ($urandom_range(0, 3) != 0);
                            @(negedge i_clk);
                        end
                    end
                endcase
            end
        end
    end

    function automatic logic [SMP_W-1:0] rand_sample();
        case ($urandom_range(0, 15))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return '0;
            3: return '1;
            default: return SMP_W'($urandom);
        endcase
    endfunction

    function automatic logic [SR_W-1:0] pick_rate();
        case ($urandom_range(0, 7))
            0: return SR_W'($urandom_range(0, 999));       // every stage collapses to zero
            1: return SR_W'($urandom_range(1000, 192000));
            default: return SR_W'($urandom_range(1000, 3999));
        endcase
    endfunction

    function automatic logic [SUS_W-1:0] pick_sustain();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return LVL_ONE;
            2: return '1;
            default: return SUS_W'($urandom_range(0, 32768));
        endcase
    endfunction

    // called at a falling edge, returns at the falling edge after the transaction
    task automatic send(logic [OP_W-1:0] op, logic [SMP_W-1:0] smp);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        in_ch.valid <= 1'b1;
        in_ch.opcode <= op;
        in_ch.osc_sample <= smp;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        if (op != OP_UNUSED)
            items_sent++;
    endtask

    task automatic play(logic [OP_W-1:0] op);
        if ($urandom_range(0, 11) == 0)
            op = OP_W'($urandom_range(0, 3));
        send(op, rand_sample());
    endtask

    task automatic play_note();
        int n_hold;
        int n_tail;
        n_hold = $urandom_range(0, 24);
        n_tail = $urandom_range(0, 16);
        play(OP_NOTE_ON);
        repeat (n_hold) play(OP_TICK);
        // now and then the next note-on retriggers without a release
        if ($urandom_range(0, 4) != 0)
            play(OP_NOTE_OFF);
        repeat (n_tail) play(OP_TICK);
    endtask

    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        burst_left = 0;
        while (outstanding != 0) @(negedge i_clk);
    endtask

    task automatic reg_write(t_reg_idx idx, logic [APB_DW-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic set_envelope(logic [SR_W-1:0] rate, logic [MS_W-1:0] atk,
                                logic [MS_W-1:0] dcy, logic [SUS_W-1:0] sus,
                                logic [MS_W-1:0] rls);
        wait_idle();
        reg_write(REG_SAMPLE_RATE, rate);
        reg_write(REG_ATTACK_MS, atk);
        reg_write(REG_DECAY_MS, dcy);
        reg_write(REG_SUSTAIN, sus);
        reg_write(REG_RELEASE_MS, rls);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        settings_used++;
    endtask

    initial begin : stimulus
        int random_start;
        int phase_end;
        int phase;
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_ch.valid = 1'b0;
        in_ch.opcode = OP_TICK;
        in_ch.osc_sample = '0;
        burst_left = 0;
        items_sent = 0;
        settings_used = 0;
        stress_go = 1'b0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // power-on registers; tick and unused opcode while idle, note-off from idle
        send(OP_TICK, 16'h7FFF);
        send(OP_UNUSED, 16'h8000);
        send(OP_NOTE_OFF, 16'h1234);
        send(OP_TICK, 16'h7FFF);
        send(OP_TICK, 16'h8000);
        send(OP_NOTE_ON, 16'h0000);
        send(OP_TICK, 16'h7FFF);
        send(OP_TICK, 16'h8000);

        // zero attack/decay/release, sustain above full scale
        set_envelope(18'd1000, 14'd0, 14'd0, 16'hFFFF, 14'd0);
        send(OP_TICK, 16'h8000);
        send(OP_TICK, 16'h7FFF);
        send(OP_TICK, 16'hFFFF);
        send(OP_NOTE_OFF, 16'h0000);
        send(OP_TICK, 16'h7FFF);
        send(OP_NOTE_ON, 16'h0000);
        send(OP_TICK, 16'h7FFF);

        // short stages, zero sustain ends the decay in done
        set_envelope(18'd2999, 14'd1, 14'd1, 16'd0, 14'd1);
        repeat (5) send(OP_TICK, 16'h4000);
        send(OP_NOTE_OFF, 16'h0000);

        // decay entered, then attack stretched and decay cut to zero mid-decay
        set_envelope(18'd1000, 14'd2, 14'd4, 16'd20000, 14'd3);
        send(OP_NOTE_ON, 16'h0000);
        repeat (4) send(OP_TICK, 16'h7FFF);
        set_envelope(18'd1000, 14'd50, 14'd0, 16'd20000, 14'd3);
        send(OP_TICK, 16'h8000);
        send(OP_NOTE_OFF, 16'h0000);
        repeat (2) send(OP_TICK, 16'h7FFF);

        stress_go = 1'b1;
        random_start = items_sent;
        phase = 0;
        while (items_sent - random_start < RANDOM_ITEMS) begin
            case (phase)
                0: set_envelope(18'd192000, 14'd10000, 14'd10000, LVL_ONE, 14'd10000);
                1: set_envelope(18'd1000, 14'd0, 14'd0, 16'hFFFF, 14'd0);
                default: set_envelope(pick_rate(), MS_W'($urandom_range(0, 8)),
                                      MS_W'($urandom_range(0, 8)), pick_sustain(),
                                      MS_W'($urandom_range(0, 8)));
            endcase
            phase_end = items_sent + $urandom_range(60, 140);
            while (items_sent < phase_end)
                play_note();
            phase++;
        end

        wait_idle();
        repeat (30) @(negedge i_clk);
        $display("%0d note/tick transactions sent over %0d register settings, %0d results compared",
                 items_sent, settings_used, compared_total);
        $display("long output hold-off exercised: %0d", stress_done);
        if (mismatch_total == 0 && outstanding == 0)
            $display("adsr_envelope_generator_test: clean");
        else
            $display("adsr_envelope_generator_test: errors");
        $finish;
    end

endmodule
